FILE: design/gbts_pkg.sv
// shared types and constants for the gap buffer text store
package gbts_pkg;

    localparam int CHAR_W = 8;
    localparam int POS_W  = 11;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_MOVE   = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD_WAIT,
        S_MV_RD,
        S_MV_WR,
        S_FINISH
    } state_t;

endpackage

FILE: design/gbts_ram.sv
// generic single-write, single-read ram with registered read data
module gbts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/gap_buffer_text_store.sv
// gap buffer text store: top level with sequencer, pointers and result register
// steps: accept, execute, finish for insert, delete, refused or null move; a read adds a wait
// for ram data, a move a read and a write per byte carried; finish stalls while a result waits
// throughput: one item at a time; the next beat is taken once the sequencer is idle,
// even while the previous result still waits on the output register
// reset: cursor and length clear, gap end goes to capacity; text ram is not cleared
module gap_buffer_text_store #(
    parameter int CAPACITY = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     action,
    input  logic [gbts_pkg::CHAR_W-1:0]    char_in,
    input  logic [gbts_pkg::POS_W-1:0]     position,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     status,
    output logic [gbts_pkg::CHAR_W-1:0]    char_out,
    output logic [gbts_pkg::POS_W-1:0]     cursor,
    output logic [gbts_pkg::POS_W-1:0]     text_length
);

    // pointer width holds capacity itself, address width indexes the ram
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    // compare width covers both the position port and the pointers
    localparam int EW = (PW > gbts_pkg::POS_W) ? PW : gbts_pkg::POS_W;

    gbts_pkg::state_t  state_reg, state_next;
    gbts_pkg::action_t act_reg, act_next;
    gbts_pkg::status_t st_reg, st_next;

    logic [gbts_pkg::CHAR_W-1:0] char_reg, char_next;
    logic [EW-1:0]               pos_reg, pos_next;
    logic [PW-1:0]               gb_reg, gb_next;     // gap start, the cursor
    logic [PW-1:0]               gf_reg, gf_next;     // gap end
    logic [PW-1:0]               cnt_reg, cnt_next;   // text length
    logic [gbts_pkg::CHAR_W-1:0] rd_reg, rd_next;

    // result register, decoupled from the sequencer
    logic                        out_valid_reg, out_valid_next;
    gbts_pkg::status_t           out_st_reg, out_st_next;
    logic [gbts_pkg::CHAR_W-1:0] out_char_reg, out_char_next;
    logic [gbts_pkg::POS_W-1:0]  out_cur_reg, out_cur_next;
    logic [gbts_pkg::POS_W-1:0]  out_len_reg, out_len_next;

    // text ram port signals
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [gbts_pkg::CHAR_W-1:0] mem_wdata;
    logic                        mem_re;
    logic [AW-1:0]               mem_raddr;
    logic [gbts_pkg::CHAR_W-1:0] mem_rdata;

    logic [EW-1:0] gb_ext;
    logic [EW-1:0] cnt_ext;
    logic [EW-1:0] read_idx;
    logic          move_left;
    logic          out_free;

    gbts_ram #(
        .WIDTH (gbts_pkg::CHAR_W),
        .DEPTH (CAPACITY)
    ) u_text_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign gb_ext    = EW'(gb_reg);
    assign cnt_ext   = EW'(cnt_reg);
    // logical index past the cursor skips the gap
    assign read_idx  = (pos_reg < gb_ext) ? pos_reg : pos_reg + EW'(gf_reg - gb_reg);
    // target before the cursor: carry bytes from the left side to the right side
    assign move_left = (pos_reg < gb_ext);
    assign out_free  = !out_valid_reg || out_ready;

    assign in_ready    = (state_reg == gbts_pkg::S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = out_st_reg;
    assign char_out    = out_char_reg;
    assign cursor      = out_cur_reg;
    assign text_length = out_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gbts_pkg::S_IDLE;
            gb_reg        <= '0;
            gf_reg        <= PW'(CAPACITY);
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gb_reg        <= gb_next;
            gf_reg        <= gf_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        st_reg       <= st_next;
        char_reg     <= char_next;
        pos_reg      <= pos_next;
        rd_reg       <= rd_next;
        out_st_reg   <= out_st_next;
        out_char_reg <= out_char_next;
        out_cur_reg  <= out_cur_next;
        out_len_reg  <= out_len_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        st_next        = st_reg;
        char_next      = char_reg;
        pos_next       = pos_reg;
        rd_next        = rd_reg;
        gb_next        = gb_reg;
        gf_next        = gf_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_st_next    = out_st_reg;
        out_char_next  = out_char_reg;
        out_cur_next   = out_cur_reg;
        out_len_next   = out_len_reg;
        mem_we         = 1'b0;
        mem_waddr      = gb_reg[AW-1:0];
        mem_wdata      = char_reg;
        mem_re         = 1'b0;
        mem_raddr      = read_idx[AW-1:0];

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            gbts_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next   = gbts_pkg::action_t'(action);
                    char_next  = char_in;
                    pos_next   = EW'(position);
                    st_next    = gbts_pkg::ST_DONE;
                    rd_next    = '0;
                    state_next = gbts_pkg::S_EXEC;
                end
            end

            gbts_pkg::S_EXEC:
            begin
                state_next = gbts_pkg::S_FINISH;
                case (act_reg)
                    gbts_pkg::ACT_INSERT:
                    begin
                        if (gb_reg < gf_reg)
                        begin
                            mem_we   = 1'b1;
                            gb_next  = gb_reg + 1'b1;
                            cnt_next = cnt_reg + 1'b1;
                        end
                        else
                        begin
                            st_next = gbts_pkg::ST_FULL;
                        end
                    end
                    gbts_pkg::ACT_DELETE:
                    begin
                        if (gb_reg == '0)
                        begin
                            st_next = gbts_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            gb_next  = gb_reg - 1'b1;
                            cnt_next = cnt_reg - 1'b1;
                        end
                    end
                    gbts_pkg::ACT_MOVE:
                    begin
                        if (pos_reg > cnt_ext)
                        begin
                            st_next = gbts_pkg::ST_RANGE;
                        end
                        else if (pos_reg != gb_ext)
                        begin
                            state_next = gbts_pkg::S_MV_RD;
                        end
                    end
                    gbts_pkg::ACT_READ:
                    begin
                        if (pos_reg >= cnt_ext)
                        begin
                            st_next = gbts_pkg::ST_RANGE;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            state_next = gbts_pkg::S_RD_WAIT;
                        end
                    end
                    default:
                    begin
                        st_next = gbts_pkg::ST_DONE;
                    end
                endcase
            end

            gbts_pkg::S_RD_WAIT:
            begin
                rd_next    = mem_rdata;
                state_next = gbts_pkg::S_FINISH;
            end

            // fetch the byte next to the gap on the side the cursor moves toward
            gbts_pkg::S_MV_RD:
            begin
                if (pos_reg == gb_ext)
                begin
                    state_next = gbts_pkg::S_FINISH;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = move_left ? AW'(gb_reg - 1'b1) : gf_reg[AW-1:0];
                    state_next = gbts_pkg::S_MV_WR;
                end
            end

            // drop it on the far side and slide the gap one place
            gbts_pkg::S_MV_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                if (move_left)
                begin
                    mem_waddr = AW'(gf_reg - 1'b1);
                    gb_next   = gb_reg - 1'b1;
                    gf_next   = gf_reg - 1'b1;
                end
                else
                begin
                    mem_waddr = gb_reg[AW-1:0];
                    gb_next   = gb_reg + 1'b1;
                    gf_next   = gf_reg + 1'b1;
                end
                state_next = gbts_pkg::S_MV_RD;
            end

            gbts_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_st_next    = st_reg;
                    out_char_next  = rd_reg;
                    out_cur_next   = gb_ext[gbts_pkg::POS_W-1:0];
                    out_len_next   = cnt_ext[gbts_pkg::POS_W-1:0];
                    state_next     = gbts_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = gbts_pkg::S_IDLE;
            end
        endcase
    end

    // gap never inverts and never runs past the store
    a_gap_order: assert property (@(posedge clk) disable iff (!rst_n)
        (gb_reg <= gf_reg) && (gf_reg <= PW'(CAPACITY)))
        else $error("gap pointers out of order");

    // length always matches text on both sides of the gap
    a_len_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (EW'(cnt_reg) + EW'(gf_reg) == EW'(gb_reg) + EW'(CAPACITY)))
        else $error("text length disagrees with gap pointers");

    // ram is only written while executing an insert or carrying a byte
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((state_reg == gbts_pkg::S_EXEC) || (state_reg == gbts_pkg::S_MV_WR)))
        else $error("text ram written outside insert or move");

    // a result is loaded only from the finish step
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == gbts_pkg::S_FINISH))
        else $error("result raised outside finish step");

endmodule

FILE: bench/gap_buffer_text_store_tb.sv
// self-checking bench for the gap buffer text store: edit scoreboard plus beat drivers
module gap_buffer_text_store_tb;

    localparam int CAP         = 1024;
    // a full-length move copies 1024 bytes, each by a read and a write step; allow for several such moves
    localparam int STALL_LIMIT = 12000;

    // one reply the store is expected to return
    typedef struct {
        gbts_pkg::status_t                 status;
        logic [gbts_pkg::CHAR_W-1:0]       ch;
        logic [gbts_pkg::POS_W-1:0]        cur;
        logic [gbts_pkg::POS_W-1:0]        len;
    } reply_t;

    // tracks the text, the gap and the replies still owed by the store
    class gap_text_scoreboard;
        logic [gbts_pkg::CHAR_W-1:0] text_mem [CAP];
        int                          gap_lo;
        int                          gap_hi;
        int                          count;
        int                          errors;
        reply_t                      replies_due [$];

        function new();
            gap_lo = 0;
            gap_hi = CAP;
            count  = 0;
            errors = 0;
        endfunction

        // slide the gap one byte at a time until it opens at target
        function void carry_gap(int target);
            while (target < gap_lo)
            begin
                gap_lo--;
                gap_hi--;
                text_mem[gap_hi] = text_mem[gap_lo];
            end
            while (target > gap_lo && gap_hi < CAP)
            begin
                text_mem[gap_lo] = text_mem[gap_hi];
                gap_lo++;
                gap_hi++;
            end
        endfunction

        // apply one accepted edit and queue the reply it owes
        function void note_beat(gbts_pkg::action_t act, logic [gbts_pkg::CHAR_W-1:0] ch,
                                logic [gbts_pkg::POS_W-1:0] pos);
            reply_t r;
            int     p;
            p        = pos;
            r.status = gbts_pkg::ST_DONE;
            r.ch     = '0;
            case (act)
                gbts_pkg::ACT_INSERT:
                    if (gap_lo >= gap_hi)
                        r.status = gbts_pkg::ST_FULL;
                    else
                    begin
                        text_mem[gap_lo] = ch;
                        gap_lo++;
                        count++;
                    end
                gbts_pkg::ACT_DELETE:
                    if (gap_lo == 0)
                        r.status = gbts_pkg::ST_EMPTY;
                    else
                    begin
                        gap_lo--;
                        count--;
                    end
                gbts_pkg::ACT_MOVE:
                    if (p > count)
                        r.status = gbts_pkg::ST_RANGE;
                    else
                        carry_gap(p);
                default:
                    if (p >= count)
                        r.status = gbts_pkg::ST_RANGE;
                    else
                        r.ch = text_mem[(p < gap_lo) ? p : p + gap_hi - gap_lo];
            endcase
            r.cur = gap_lo[gbts_pkg::POS_W-1:0];
            r.len = count[gbts_pkg::POS_W-1:0];
            replies_due.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        // compare one reply beat against the oldest owed reply
        task check_beat(logic [1:0] st, logic [gbts_pkg::CHAR_W-1:0] ch,
                        logic [gbts_pkg::POS_W-1:0] cur, logic [gbts_pkg::POS_W-1:0] len);
            reply_t r;
            if (replies_due.size() == 0)
            begin
                report($sformatf("unexpected reply status %0d char %0h cursor %0d length %0d",
                                 st, ch, cur, len));
                return;
            end
            r = replies_due.pop_front();
            if (st !== r.status)
                report($sformatf("status got %0d want %0d", st, r.status));
            if (ch !== r.ch)
                report($sformatf("char_out got %0h want %0h", ch, r.ch));
            if (cur !== r.cur)
                report($sformatf("cursor got %0d want %0d", cur, r.cur));
            if (len !== r.len)
                report($sformatf("text_length got %0d want %0d", len, r.len));
        endtask
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic [1:0]                   action;
    logic [gbts_pkg::CHAR_W-1:0]  char_in;
    logic [gbts_pkg::POS_W-1:0]   position;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [1:0]                   status;
    logic [gbts_pkg::CHAR_W-1:0]  char_out;
    logic [gbts_pkg::POS_W-1:0]   cursor;
    logic [gbts_pkg::POS_W-1:0]   text_length;

    // chance in a hundred that a side sits out a cycle
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    gap_text_scoreboard tracker;

    gap_buffer_text_store #(
        .CAPACITY (CAP)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .char_in     (char_in),
        .position    (position),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .char_out    (char_out),
        .cursor      (cursor),
        .text_length (text_length)
    );

    always #10 clk = ~clk;

    // receiver: ready changes only on the falling edge
    always @(negedge clk)
    begin
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // reply beats are taken at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_beat(status, char_out, cursor, text_length);
    end

    // watchdog: too many cycles in a row without any beat means the store hung
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("gap_buffer_text_store_tb: errors");
        $finish;
    end

    // offer one edit beat, with random idle cycles ahead of it, and hold it until taken
    task automatic drive_beat(gbts_pkg::action_t act, logic [gbts_pkg::CHAR_W-1:0] ch,
                              logic [gbts_pkg::POS_W-1:0] pos);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        char_in  <= ch;
        position <= pos;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.note_beat(act, ch, pos);
    endtask

    // hold the sender off until every owed reply has come back
    task automatic drain_replies();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.replies_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // one random edit; ins_pct sets how fast the text grows
    task automatic drive_random(int ins_pct);
        int                r;
        int                p;
        int                lo;
        int                hi;
        gbts_pkg::action_t act;
        r = $urandom_range(99);
        if (r < ins_pct)
            act = gbts_pkg::ACT_INSERT;
        else if (r < ins_pct + 12)
            act = gbts_pkg::ACT_DELETE;
        else if (r < ins_pct + 12 + (88 - ins_pct) / 2)
            act = gbts_pkg::ACT_MOVE;
        else
            act = gbts_pkg::ACT_READ;
        r = $urandom_range(99);
        if (r < 8)
            p = $urandom_range(2047);                   // any position, mostly out of range
        else if (r < 14)
            p = tracker.count + $urandom_range(1);      // right at the end of the text
        else if (act == gbts_pkg::ACT_MOVE && r < 60)
        begin
            // short hops around the cursor keep moves cheap
            lo = (tracker.gap_lo > 16) ? tracker.gap_lo - 16 : 0;
            hi = (tracker.gap_lo + 16 < tracker.count) ? tracker.gap_lo + 16 : tracker.count;
            p  = $urandom_range(hi, lo);
        end
        else if (act == gbts_pkg::ACT_READ)
            p = $urandom_range((tracker.count > 0) ? tracker.count - 1 : 0);
        else
            p = $urandom_range(tracker.count);
        drive_beat(act, gbts_pkg::CHAR_W'($urandom_range(255)), gbts_pkg::POS_W'(p));
        // now and then let the store run dry before going on
        if ($urandom_range(199) == 0)
            drain_replies();
    endtask

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        action   = gbts_pkg::ACT_INSERT;
        char_in  = '0;
        position = '0;
        tracker  = new();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: edits on an empty store
        drive_beat(gbts_pkg::ACT_DELETE, 8'h00, 11'd0);     // nothing to delete
        drive_beat(gbts_pkg::ACT_READ,   8'h00, 11'd0);     // read past the text
        drive_beat(gbts_pkg::ACT_MOVE,   8'h00, 11'd0);     // move onto the cursor
        drive_beat(gbts_pkg::ACT_MOVE,   8'h00, 11'd1);     // move past the text
        // a little text with extreme bytes
        drive_beat(gbts_pkg::ACT_INSERT, 8'h00, 11'd0);
        drive_beat(gbts_pkg::ACT_INSERT, 8'hFF, 11'h7FF);
        drive_beat(gbts_pkg::ACT_INSERT, 8'hA5, 11'd0);
        drive_beat(gbts_pkg::ACT_READ,   8'h00, 11'd0);
        drive_beat(gbts_pkg::ACT_READ,   8'h00, 11'd2);
        drive_beat(gbts_pkg::ACT_READ,   8'h00, 11'd3);     // one past the last byte
        drive_beat(gbts_pkg::ACT_READ,   8'hFF, 11'h7FF);
        drive_beat(gbts_pkg::ACT_MOVE,   8'hFF, 11'h7FF);
        // open the gap in the middle and read across it
        drive_beat(gbts_pkg::ACT_MOVE,   8'h00, 11'd1);
        drive_beat(gbts_pkg::ACT_READ,   8'h00, 11'd1);
        drive_beat(gbts_pkg::ACT_READ,   8'h00, 11'd2);
        drive_beat(gbts_pkg::ACT_INSERT, 8'h5A, 11'd0);
        drive_beat(gbts_pkg::ACT_MOVE,   8'h00, 11'd4);
        drive_beat(gbts_pkg::ACT_MOVE,   8'h00, 11'd4);     // already there
        drive_beat(gbts_pkg::ACT_DELETE, 8'h00, 11'd0);
        drive_beat(gbts_pkg::ACT_MOVE,   8'h00, 11'd0);
        drive_beat(gbts_pkg::ACT_DELETE, 8'h00, 11'd0);     // cursor at the front, text behind
        drive_beat(gbts_pkg::ACT_READ,   8'h00, 11'd0);
        drive_beat(gbts_pkg::ACT_INSERT, 8'h01, 11'd0);
        drive_beat(gbts_pkg::ACT_READ,   8'h00, 11'd0);
        drain_replies();

        // random edits, sender mostly busy, receiver often stalled
        send_idle_pct = 8;
        recv_idle_pct = 53;
        repeat (250) drive_random(65);
        drain_replies();

        // sender often idle, receiver mostly ready
        send_idle_pct = 53;
        recv_idle_pct = 8;
        repeat (250) drive_random(65);
        drain_replies();

        // no idling: fill the store to capacity, then edit around a full buffer
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (tracker.count < CAP)
            drive_beat(gbts_pkg::ACT_INSERT, gbts_pkg::CHAR_W'($urandom_range(255)),
                       gbts_pkg::POS_W'($urandom_range(2047)));
        drive_beat(gbts_pkg::ACT_INSERT, 8'hC3, 11'd0);     // refused, no room left
        repeat (100) drive_random(40);

        drain_replies();
        repeat (40) @(posedge clk);
        if (tracker.errors == 0 && tracker.replies_due.size() == 0)
            $display("gap_buffer_text_store_tb: clean");
        else
            $display("gap_buffer_text_store_tb: errors");
        $finish;
    end

endmodule

FILE: sim.f
design/gbts_pkg.sv
design/gbts_ram.sv
design/gap_buffer_text_store.sv
bench/gap_buffer_text_store_tb.sv
